### rtl/ft8cp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ft8cp_pkg
// Shared types, constants and character helpers for the c28 callsign packer.
// ----------------------------------------------------------------------------
package ft8cp_pkg;

  localparam int unsigned NUM_LANES = 6;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_Q     = 8'h51;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_Z     = 8'h5A;

  localparam logic [1:0] TOK_DE  = 2'd0;
  localparam logic [1:0] TOK_QRZ = 2'd1;
  localparam logic [1:0] TOK_CQ  = 2'd2;

  // mixed radix 37,36,10,27,27,27 flattened into per-position weights
  localparam logic [27:0] W_A      = 28'd7085880;
  localparam logic [27:0] W_B      = 28'd196830;
  localparam logic [27:0] W_C      = 28'd19683;
  localparam logic [27:0] W_D      = 28'd729;
  localparam logic [27:0] W_E      = 28'd27;
  localparam logic [27:0] C28_BASE = 28'd6257896;

  typedef struct packed {
    logic [7:0] char0;
    logic [7:0] char1;
    logic [7:0] char2;
    logic [7:0] char3;
    logic [7:0] char4;
    logic [7:0] char5;
    logic [3:0] length;
  } in_item_t;

  typedef struct packed {
    logic        valid_res;
    logic [27:0] packed_res;
  } out_item_t;

  // what one lane learns about its character
  typedef struct packed {
    logic [7:0] ch;
    logic       is_dig;
    logic       ok37;
    logic [5:0] v37;
    logic       ok27;
    logic [4:0] v27;
  } lane_info_t;

  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } pipe_ctl_t;

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_LA && c <= CH_LZ) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

  function automatic lane_info_t classify(input logic [7:0] c);
    lane_info_t r;
    r.ch     = c;
    r.is_dig = (c >= CH_0) && (c <= CH_9);
    r.ok37   = 1'b0;
    r.v37    = '0;
    r.ok27   = 1'b0;
    r.v27    = '0;
    if (c == CH_SPACE) begin
      r.ok37 = 1'b1;
      r.ok27 = 1'b1;
    end else if (r.is_dig) begin
      r.ok37 = 1'b1;
      r.v37  = 6'(c - CH_0) + 6'd1;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      r.ok37 = 1'b1;
      r.v37  = 6'(c - CH_UA) + 6'd11;
      r.ok27 = 1'b1;
      r.v27  = 5'(c - CH_UA) + 5'd1;
    end
    return r;
  endfunction

endpackage

### rtl/ft8cp_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ft8cp_lane
// One character lane: case fold and alphabet classification, registered.
// ----------------------------------------------------------------------------
module ft8cp_lane (
  input  logic                   clk,
  input  logic                   en,
  input  logic [7:0]             ch_i,
  output ft8cp_pkg::lane_info_t  info_o
);

  ft8cp_pkg::lane_info_t info_r;
  ft8cp_pkg::lane_info_t info_nxt;

  always_comb begin
    info_nxt = ft8cp_pkg::classify(ft8cp_pkg::fold_upper(ch_i));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      info_r <= info_nxt;
    end
  end

  assign info_o = info_r;

endmodule

### rtl/ft8cp_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ft8cp_merge
// Combines the lane results: token match, alignment, padding, position checks,
// weighted products (one stage) and the final sum (output stage).
// ----------------------------------------------------------------------------
module ft8cp_merge (
  input  logic                   clk,
  input  ft8cp_pkg::pipe_ctl_t   ctl,
  input  ft8cp_pkg::lane_info_t  lane_i [ft8cp_pkg::NUM_LANES],
  input  logic [3:0]             len_i,
  output ft8cp_pkg::out_item_t   item_o
);

  ft8cp_pkg::lane_info_t six [ft8cp_pkg::NUM_LANES];
  ft8cp_pkg::lane_info_t sp_info;
  logic       shift;
  logic       tok_hit;
  logic [1:0] tok_val;
  logic       ok;

  logic        tok_hit_r, tok_hit_nxt;
  logic [1:0]  tok_val_r, tok_val_nxt;
  logic        ok_r,      ok_nxt;
  logic [27:0] pa_r,      pa_nxt;
  logic [27:0] pb_r,      pb_nxt;
  logic [27:0] pc_r,      pc_nxt;
  logic [14:0] pdef_r,    pdef_nxt;
  ft8cp_pkg::out_item_t out_r, out_nxt;

  always_comb begin
    sp_info = ft8cp_pkg::classify(ft8cp_pkg::CH_SPACE);
    tok_hit = 1'b0;
    tok_val = ft8cp_pkg::TOK_DE;
    if (len_i == 4'd2 && lane_i[0].ch == ft8cp_pkg::CH_D && lane_i[1].ch == ft8cp_pkg::CH_E) begin
      tok_hit = 1'b1;
      tok_val = ft8cp_pkg::TOK_DE;
    end else if (len_i == 4'd3 && lane_i[0].ch == ft8cp_pkg::CH_Q
                 && lane_i[1].ch == ft8cp_pkg::CH_R && lane_i[2].ch == ft8cp_pkg::CH_Z) begin
      tok_hit = 1'b1;
      tok_val = ft8cp_pkg::TOK_QRZ;
    end else if (len_i == 4'd2 && lane_i[0].ch == ft8cp_pkg::CH_C
                 && lane_i[1].ch == ft8cp_pkg::CH_Q) begin
      tok_hit = 1'b1;
      tok_val = ft8cp_pkg::TOK_CQ;
    end

    // digit in third place keeps alignment, else a leading space is added
    shift = !lane_i[2].is_dig;
    for (int i = 0; i < ft8cp_pkg::NUM_LANES; i++) begin
      six[i] = sp_info;
    end
    for (int i = 0; i < ft8cp_pkg::NUM_LANES; i++) begin
      if (4'(i) < len_i) begin
        if (!shift) begin
          six[i] = lane_i[i];
        end else if (i < ft8cp_pkg::NUM_LANES - 1) begin
          six[i + 1] = lane_i[i];
        end
      end
    end

    ok = (len_i >= 4'd3) && (len_i <= 4'd6)
         && (lane_i[2].is_dig || (lane_i[1].is_dig && len_i <= 4'd5))
         && six[0].ok37
         && six[1].ok37 && (six[1].v37 != 6'd0)
         && six[2].is_dig
         && six[3].ok27 && six[4].ok27 && six[5].ok27;

    tok_hit_nxt = tok_hit;
    tok_val_nxt = tok_val;
    ok_nxt      = ok;
    pa_nxt      = 28'(six[0].v37) * ft8cp_pkg::W_A;
    pb_nxt      = 28'(six[1].v37 - 6'd1) * ft8cp_pkg::W_B;
    pc_nxt      = 28'(six[2].v37 - 6'd1) * ft8cp_pkg::W_C;
    pdef_nxt    = 15'(28'(six[3].v27) * ft8cp_pkg::W_D
                      + 28'(six[4].v27) * ft8cp_pkg::W_E
                      + 28'(six[5].v27));
  end

  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      tok_hit_r <= tok_hit_nxt;
      tok_val_r <= tok_val_nxt;
      ok_r      <= ok_nxt;
      pa_r      <= pa_nxt;
      pb_r      <= pb_nxt;
      pc_r      <= pc_nxt;
      pdef_r    <= pdef_nxt;
    end
  end

  always_comb begin
    out_nxt = '0;
    if (tok_hit_r) begin
      out_nxt.valid_res  = 1'b1;
      out_nxt.packed_res = 28'(tok_val_r);
    end else if (ok_r) begin
      out_nxt.valid_res  = 1'b1;
      out_nxt.packed_res = pa_r + pb_r + pc_r + 28'(pdef_r) + ft8cp_pkg::C28_BASE;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en3) begin
      out_r <= out_nxt;
    end
  end

  assign item_o = out_r;

endmodule

### rtl/ft8_callsign_packer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ft8_callsign_packer_core
// Packs a callsign of up to six characters into the 28-bit c28 field.
// ----------------------------------------------------------------------------
// One item per clock unless a stalled result backs up the pipeline:
// six character lanes fold and classify in the first stage, the merge stage
// aligns, checks and forms the weighted products in the second, and the sum
// lands in the output register in the third. Each stage holds one item and
// fills a bubble even while out_stall holds the result, so in_stall rises
// only when all three stages are full and the output is stalled.
module ft8_callsign_packer_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ft8cp_pkg::in_item_t   in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ft8cp_pkg::out_item_t  out_item
);

  logic v1_r, v1_nxt;
  logic v2_r, v2_nxt;
  logic v3_r, v3_nxt;
  logic [3:0] len_r;
  logic rdy1, rdy2, rdy3;
  ft8cp_pkg::pipe_ctl_t ctl;
  ft8cp_pkg::lane_info_t lane_info [ft8cp_pkg::NUM_LANES];
  logic [7:0] lane_ch [ft8cp_pkg::NUM_LANES];

  assign rdy3 = !v3_r || !out_stall;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  always_comb begin
    ctl.en1 = in_valid && rdy1;
    ctl.en2 = v1_r && rdy2;
    ctl.en3 = v2_r && rdy3;
    v1_nxt  = ctl.en1 ? 1'b1 : (ctl.en2 ? 1'b0 : v1_r);
    v2_nxt  = ctl.en2 ? 1'b1 : (ctl.en3 ? 1'b0 : v2_r);
    v3_nxt  = ctl.en3 ? 1'b1 : (out_stall ? v3_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      len_r <= in_item.length;
    end
  end

  assign lane_ch[0] = in_item.char0;
  assign lane_ch[1] = in_item.char1;
  assign lane_ch[2] = in_item.char2;
  assign lane_ch[3] = in_item.char3;
  assign lane_ch[4] = in_item.char4;
  assign lane_ch[5] = in_item.char5;

  for (genvar g = 0; g < ft8cp_pkg::NUM_LANES; g++) begin : g_lane
    ft8cp_lane u_lane (
      .clk    (clk),
      .en     (ctl.en1),
      .ch_i   (lane_ch[g]),
      .info_o (lane_info[g])
    );
  end

  ft8cp_merge u_merge (
    .clk    (clk),
    .ctl    (ctl),
    .lane_i (lane_info),
    .len_i  (len_r),
    .item_o (out_item)
  );

  assign in_stall  = !rdy1;
  assign out_valid = v3_r;

endmodule

### rtl/ft8cp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ft8cp_checker
// Port-level checks for the callsign packer, bound to the top level.
// ----------------------------------------------------------------------------
module ft8cp_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input ft8cp_pkg::out_item_t  out_item
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled item changed");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.valid_res |-> out_item.packed_res == 28'd0)
    else $error("rejected item carries nonzero value");

  // packed calls sit above the token codes
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.valid_res && out_item.packed_res > 28'd2
    |-> out_item.packed_res >= ft8cp_pkg::C28_BASE)
    else $error("packed value in reserved range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind ft8_callsign_packer_core ft8cp_checker u_ft8cp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

### verif/ft8cp_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ft8cp_tb_pkg
// Scoreboard for the c28 callsign packer: predicts the packed field of every
// accepted callsign and checks the results in order of arrival.
// ----------------------------------------------------------------------------
package ft8cp_tb_pkg;

  import ft8cp_pkg::*;

  class c28_scoreboard;

    out_item_t   pending_c28[$];
    int unsigned n_calls;
    int unsigned n_packed;
    int unsigned n_tokens;
    int unsigned n_rejected;
    int unsigned n_checked;
    int unsigned n_errors;

    function logic [7:0] upcase(logic [7:0] c);
      return (c >= CH_LA && c <= CH_LZ) ? c - 8'd32 : c;
    endfunction

    function bit is_digit(logic [7:0] c);
      return (c >= CH_0) && (c <= CH_9);
    endfunction

    // space 0, digits 1..10, letters 11..36
    function int alpha37(logic [7:0] c);
      if (c == CH_SPACE) return 0;
      if (is_digit(c)) return 1 + int'(c - CH_0);
      if (c >= CH_UA && c <= CH_UZ) return 11 + int'(c - CH_UA);
      return -1;
    endfunction

    // space 0, letters 1..26
    function int alpha27(logic [7:0] c);
      if (c == CH_SPACE) return 0;
      if (c >= CH_UA && c <= CH_UZ) return 1 + int'(c - CH_UA);
      return -1;
    endfunction

    function out_item_t pack_callsign(in_item_t it);
      logic [7:0]  ch [6];
      logic [7:0]  six [6];
      int unsigned len;
      int unsigned n;
      int          a, b, c, d, e, f;
      out_item_t   r;
      r     = '0;
      ch[0] = upcase(it.char0);
      ch[1] = upcase(it.char1);
      ch[2] = upcase(it.char2);
      ch[3] = upcase(it.char3);
      ch[4] = upcase(it.char4);
      ch[5] = upcase(it.char5);
      len   = it.length;
      if (len == 2 && ch[0] == CH_D && ch[1] == CH_E) begin
        r.valid_res  = 1'b1;
        r.packed_res = 28'(TOK_DE);
        return r;
      end
      if (len == 3 && ch[0] == CH_Q && ch[1] == CH_R && ch[2] == CH_Z) begin
        r.valid_res  = 1'b1;
        r.packed_res = 28'(TOK_QRZ);
        return r;
      end
      if (len == 2 && ch[0] == CH_C && ch[1] == CH_Q) begin
        r.valid_res  = 1'b1;
        r.packed_res = 28'(TOK_CQ);
        return r;
      end
      if (len < 3 || len > 6) return r;
      for (int i = 0; i < 6; i++) six[i] = CH_SPACE;
      if (is_digit(ch[2])) begin
        for (int i = 0; i < 6; i++) if (i < len) six[i] = ch[i];
      end else if (is_digit(ch[1])) begin
        // leading space added, a six character call no longer fits
        if (len > 5) return r;
        for (int i = 0; i < 5; i++) if (i < len) six[i + 1] = ch[i];
      end else begin
        return r;
      end
      a = alpha37(six[0]);
      b = alpha37(six[1]);
      c = alpha37(six[2]);
      d = alpha27(six[3]);
      e = alpha27(six[4]);
      f = alpha27(six[5]);
      if (a < 0 || b <= 0 || c < 1 || c > 10 || d < 0 || e < 0 || f < 0) return r;
      n = a;
      n = n * 36 + (b - 1);
      n = n * 10 + (c - 1);
      n = n * 27 + d;
      n = n * 27 + e;
      n = n * 27 + f;
      n = n + C28_BASE;
      r.valid_res  = 1'b1;
      r.packed_res = 28'(n);
      return r;
    endfunction

    function int unsigned pending();
      return pending_c28.size();
    endfunction

    function void flag(string msg);
      n_errors++;
      if (n_errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void note_call(in_item_t it);
      out_item_t expd;
      expd = pack_callsign(it);
      n_calls++;
      if (!expd.valid_res) n_rejected++;
      else if (expd.packed_res < 28'd3) n_tokens++;
      else n_packed++;
      pending_c28.insert(pending_c28.size(), expd);
    endfunction

    function void check_c28(out_item_t got);
      out_item_t expd;
      n_checked++;
      if (pending_c28.size() == 0) begin
        flag($sformatf("unexpected result valid=%0b packed=%0d",
                       got.valid_res, got.packed_res));
        return;
      end
      expd = pending_c28.pop_front();
      if (got.valid_res !== expd.valid_res || got.packed_res !== expd.packed_res) begin
        flag($sformatf("result %0d: expected valid=%0b packed=%0d, got valid=%0b packed=%0d",
                       n_checked, expd.valid_res, expd.packed_res,
                       got.valid_res, got.packed_res));
      end
    endfunction

  endclass

endpackage

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for ft8_callsign_packer_core: directed tokens, edge
// lengths and malformed calls, then bursts of random callsigns against a
// stalling receiver, every result compared with the scoreboard prediction.
// ----------------------------------------------------------------------------
module tb_top;

  import ft8cp_pkg::*;
  import ft8cp_tb_pkg::*;

  localparam int unsigned N_RANDOM       = 1800;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_RUNS
  } stall_mode_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;

  bit          in_fire;
  bit          out_fire;
  int unsigned idle_cycles;

  c28_scoreboard sb = new();

  ft8_callsign_packer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      in_fire  = (in_valid === 1'b1) && (in_stall === 1'b0);
      out_fire = (out_valid === 1'b1) && (out_stall === 1'b0);
      if (in_fire) sb.note_call(in_item);
      if (out_fire) sb.check_c28(out_item);
      if (in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
    end else begin
      in_fire  = 1'b0;
      out_fire = 1'b0;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, sb.pending());
    $display("FAILURE");
    $finish;
  end

  initial begin
    stall_mode_t mode;
    int unsigned span;
    int unsigned k;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(40, 300);
      k    = 0;
      repeat (span) begin
        @(negedge clk);
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
          default:     out_stall <= ((k % 16) < 10);
        endcase
        k++;
      end
    end
  end

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'(CH_UA + $urandom_range(0, 25));
    if ($urandom_range(0, 3) == 0) c = c + 8'd32;
    return c;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(CH_0 + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(0, 35) < 10) ? rand_digit() : rand_letter();
  endfunction

  function automatic in_item_t build_item(logic [7:0] c [6], int unsigned len);
    in_item_t it;
    it.char0  = c[0];
    it.char1  = c[1];
    it.char2  = c[2];
    it.char3  = c[3];
    it.char4  = c[4];
    it.char5  = c[5];
    it.length = 4'(len);
    return it;
  endfunction

  // characters past the string are random filler
  function automatic in_item_t make_call(string s, int unsigned len);
    logic [7:0] c [6];
    for (int i = 0; i < 6; i++) begin
      c[i] = (i < s.len()) ? s[i] : 8'($urandom_range(0, 255));
    end
    return build_item(c, len);
  endfunction

  function automatic in_item_t random_call();
    logic [7:0]  c [6];
    int unsigned kind;
    int unsigned len;
    int unsigned pos;
    for (int i = 0; i < 6; i++) c[i] = 8'($urandom_range(0, 255));
    kind = $urandom_range(0, 99);
    if (kind < 60 || kind >= 80) begin
      if (kind >= 90) begin
        len = $urandom_range(0, 15);
      end else if ($urandom_range(0, 1) == 0) begin
        len  = $urandom_range(3, 6);
        c[0] = ($urandom_range(0, 7) == 0) ? CH_SPACE : rand_alnum();
        c[1] = rand_alnum();
        c[2] = rand_digit();
        for (int i = 3; i < 6; i++) begin
          c[i] = ($urandom_range(0, 9) == 0) ? CH_SPACE : rand_letter();
        end
      end else begin
        len  = ($urandom_range(0, 7) == 0) ? 6 : $urandom_range(3, 5);
        c[0] = rand_alnum();
        c[1] = rand_digit();
        for (int i = 2; i < 6; i++) begin
          c[i] = ($urandom_range(0, 9) == 0) ? CH_SPACE : rand_letter();
        end
      end
      // broken call: one position replaced by an arbitrary byte
      if (kind >= 80 && kind < 90) begin
        pos    = $urandom_range(0, 5);
        c[pos] = 8'($urandom_range(0, 255));
      end
    end else if (kind < 70) begin
      case ($urandom_range(0, 2))
        0: begin
          c[0] = CH_D;
          c[1] = CH_E;
          len  = 2;
        end
        1: begin
          c[0] = CH_Q;
          c[1] = CH_R;
          c[2] = CH_Z;
          len  = 3;
        end
        default: begin
          c[0] = CH_C;
          c[1] = CH_Q;
          len  = 2;
        end
      endcase
      for (int i = 0; i < 3; i++) begin
        if (i < len && $urandom_range(0, 1) == 1) c[i] = c[i] | 8'h20;
      end
      if ($urandom_range(0, 4) == 0) len = $urandom_range(0, 15);
    end else begin
      len = $urandom_range(0, 15);
    end
    return build_item(c, len);
  endfunction

  task automatic send(input in_item_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(negedge clk); while (!in_fire);
  endtask

  task automatic pause_input(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    in_item_t    it;
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    bit          paused;
    sent   = 0;
    paused = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    send(make_call("DE", 2));
    send(make_call("de", 2));
    send(make_call("QRZ", 3));
    send(make_call("qRz", 3));
    send(make_call("CQ", 2));
    send(make_call("cq", 2));
    send(make_call("DEX", 3));
    send(make_call("QRZ?", 4));
    send(make_call("A", 1));
    send(make_call("", 0));
    send(make_call("AB1CDE", 7));
    send(make_call("AB1CDE", 15));
    send(make_call("AB1CDE", 6));
    send(make_call("A1BCD", 5));
    send(make_call("A1BCDE", 6));
    send(make_call("ab1cde", 6));
    send(make_call("ZZ9ZZZ", 6));
    send(make_call(" 00", 3));
    send(make_call("AB1 C", 5));
    send(make_call("A 1", 3));
    send(make_call("ABCDEF", 6));
    send(make_call("AB1C/E", 6));
    it = make_call("AB1", 4);
    it.char3 = 8'hC1;
    send(it);
    it = make_call("0A1", 5);
    it.char3 = 8'h09;
    send(it);
    it = '1;
    send(it);
    it = '0;
    send(it);
    drain_results();

    while (sent < N_RANDOM) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 24);
      repeat (burst) begin
        send(random_call());
        sent++;
      end
      if (!paused && sent >= N_RANDOM / 2) begin
        drain_results();
        paused = 1'b1;
      end else begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) pause_input(gap);
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (sb.pending() != 0) begin
      sb.flag($sformatf("%0d expected results never arrived", sb.pending()));
    end
    $display("checked %0d results for %0d callsigns: %0d packed, %0d tokens, %0d rejected",
             sb.n_checked, sb.n_calls, sb.n_packed, sb.n_tokens, sb.n_rejected);
    $display("mismatches: %0d", sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### ft8_callsign_packer_core.f
rtl/ft8cp_pkg.sv
rtl/ft8cp_lane.sv
rtl/ft8cp_merge.sv
rtl/ft8_callsign_packer_core.sv
rtl/ft8cp_checker.sv
verif/ft8cp_tb_pkg.sv
verif/tb_top.sv
